@@ sv/assert_macros.svh @@
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/mexp_pkg.sv @@
// Shared constants for the modular exponentiation block.
// No dependencies.
package mexp_pkg;

  // Fixed widths of the configuration registers and data words.
  localparam int CFG_WIDTH    = 32;
  localparam int BASE_WIDTH   = 32;
  localparam int RESULT_WIDTH = 32;

  // Configuration register indexes.
  localparam int REG_INDEX_WIDTH = 1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_MODULUS  = 1'b0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_EXPONENT = 1'b1;

endpackage

@@ sv/mexp_mulmod.sv @@
// Bit-serial interleaved multiply-reduce unit: prod = mcand * mplr mod m.
// Depends on mexp_pkg. One multiplier bit is consumed per cycle.
module mexp_mulmod import mexp_pkg::*; #(
  parameter int MOD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [MOD_WIDTH-1:0]               m,
  input  logic [MOD_WIDTH-1:0]               mcand,
  input  logic [((MOD_WIDTH > BASE_WIDTH) ? MOD_WIDTH : BASE_WIDTH)-1:0] mplr,
  input  logic [$clog2(((MOD_WIDTH > BASE_WIDTH) ? MOD_WIDTH : BASE_WIDTH) + 1)-1:0] nsteps,
  output logic                               done,
  output logic [MOD_WIDTH-1:0]               prod
);

  localparam int OPW = (MOD_WIDTH > BASE_WIDTH) ? MOD_WIDTH : BASE_WIDTH;
  localparam int CW  = $clog2(OPW + 1);
  localparam int SW  = MOD_WIDTH + 2;

  logic                 run;
  logic [CW-1:0]        cnt;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] acc_next;
  logic [MOD_WIDTH-1:0] a_reg;
  logic [OPW-1:0]       mp;
  logic [SW-1:0]        sum;
  logic [SW-1:0]        m1;
  logic [SW-1:0]        m2;

  // With acc and a_reg both below m, 2*acc + a_reg stays below 3*m, so one of
  // three candidates is the reduced value.
  always_comb begin
    m1  = SW'(m);
    m2  = m1 << 1;
    sum = {1'b0, acc, 1'b0} + (mp[OPW-1] ? SW'(a_reg) : '0);
    if (sum >= m2) begin
      acc_next = MOD_WIDTH'(sum - m2);
    end else if (sum >= m1) begin
      acc_next = MOD_WIDTH'(sum - m1);
    end else begin
      acc_next = MOD_WIDTH'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      mp    <= mplr;
      a_reg <= mcand;
      cnt   <= nsteps;
    end else if (run) begin
      acc <= acc_next;
      mp  <= mp << 1;
      cnt <= cnt - CW'(1);
    end
  end

  assign prod = acc;

endmodule

@@ sv/modular_exponentiation_top.sv @@
// The base is first reduced mod m; then for each exponent bit, from the top,
// the value is squared and, when the bit is set, multiplied by the base.
// One word at a time: start is taken only while busy is low; the shared
// multiply-reduce unit, one multiplier bit per cycle, sets the rate.
// A modulus of zero or one gives zero. The result is strobed by done for one
// cycle and cannot be stalled. Reset sets modulus and exponent to 1.
module modular_exponentiation_top import mexp_pkg::*; #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [REG_INDEX_WIDTH-1:0] wr_index,
  input  logic [CFG_WIDTH-1:0]       wr_data,
  input  logic                       start,
  input  logic [BASE_WIDTH-1:0]      base,
  output logic                       busy,
  output logic                       done,
  output logic [RESULT_WIDTH-1:0]    result
);

  localparam int OPW  = (MOD_WIDTH > BASE_WIDTH) ? MOD_WIDTH : BASE_WIDTH;
  localparam int CW   = $clog2(OPW + 1);
  localparam int EOPW = (EXP_WIDTH > CFG_WIDTH) ? EXP_WIDTH : CFG_WIDTH;
  localparam int ECW  = $clog2(EXP_WIDTH + 1);
  localparam int MSH  = OPW - MOD_WIDTH;
  localparam int BSH  = OPW - BASE_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_SQW  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_MULW = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]           state;
  logic [CFG_WIDTH-1:0] modulus;
  logic [CFG_WIDTH-1:0] exponent;
  logic [OPW-1:0]       m_wide;
  logic [MOD_WIDTH-1:0] m;
  logic                 m_small;
  logic [EOPW-1:0]      e_wide;
  logic [EXP_WIDTH-1:0] e;
  logic [EXP_WIDTH-1:0] eshift;
  logic [ECW-1:0]       ecnt;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] b_red;
  logic                 mm_start;
  logic [MOD_WIDTH-1:0] mm_mcand;
  logic [OPW-1:0]       mm_mplr;
  logic [CW-1:0]        mm_nsteps;
  logic                 mm_done;
  logic [MOD_WIDTH-1:0] mm_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= CFG_WIDTH'(1);
      exponent <= CFG_WIDTH'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_MODULUS:  modulus  <= wr_data;
        REG_EXPONENT: exponent <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    m_wide  = OPW'(modulus);
    m       = m_wide[MOD_WIDTH-1:0];
    m_small = (m <= MOD_WIDTH'(1));
    e_wide  = EOPW'(exponent);
    e       = e_wide[EXP_WIDTH-1:0];
  end

  // The base is reduced first as 1 * base mod m, its bits fed from the top.
  always_comb begin
    mm_start  = 1'b0;
    mm_mcand  = acc;
    mm_mplr   = OPW'(acc) << MSH;
    mm_nsteps = CW'(MOD_WIDTH);
    case (state)
      S_IDLE: begin
        mm_start  = start && !m_small;
        mm_mcand  = MOD_WIDTH'(1);
        mm_mplr   = OPW'(base) << BSH;
        mm_nsteps = CW'(BASE_WIDTH);
      end
      S_SQR: begin
        mm_start = 1'b1;
      end
      S_MUL: begin
        mm_start = 1'b1;
        mm_mplr  = OPW'(b_red) << MSH;
      end
      default: ;
    endcase
  end

  mexp_mulmod #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .m      (m),
    .mcand  (mm_mcand),
    .mplr   (mm_mplr),
    .nsteps (mm_nsteps),
    .done   (mm_done),
    .prod   (mm_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            eshift <= e;
            ecnt   <= ECW'(EXP_WIDTH);
            if (m_small) begin
              acc   <= '0;
              state <= S_FIN;
            end else begin
              acc   <= MOD_WIDTH'(1);
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mm_done) begin
            b_red <= mm_prod;
            state <= S_SQR;
          end
        end
        S_SQR: state <= S_SQW;
        S_SQW: begin
          if (mm_done) begin
            acc <= mm_prod;
            if (eshift[EXP_WIDTH-1]) begin
              state <= S_MUL;
            end else begin
              eshift <= eshift << 1;
              ecnt   <= ecnt - ECW'(1);
              state  <= (ecnt == ECW'(1)) ? S_FIN : S_SQR;
            end
          end
        end
        S_MUL: state <= S_MULW;
        S_MULW: begin
          if (mm_done) begin
            acc    <= mm_prod;
            eshift <= eshift << 1;
            ecnt   <= ecnt - ECW'(1);
            state  <= (ecnt == ECW'(1)) ? S_FIN : S_SQR;
          end
        end
        S_FIN: begin
          done   <= 1'b1;
          result <= RESULT_WIDTH'(acc);
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

@@ sv/mexp_checker.sv @@
// Port-level checks of the modular exponentiation block, bound to the top.
// Depends on assert_macros.svh and modular_exponentiation_top.
`include "assert_macros.svh"

module mexp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // An accepted word always makes the block busy in the cycle after it is taken.
  `CHK_ASSERT(a_accept_busy, clk, rst, start && !busy |=> busy, "accepted word did not set busy")
  // The result word is shown only once the block has gone idle.
  `CHK_ASSERT(a_done_idle, clk, rst, done |-> !busy, "done while busy")
  `CHK_ASSERT(a_done_single, clk, rst, done |=> !done, "done held longer than one cycle")
  // Leaving the busy state always delivers a word.
  `CHK_ASSERT(a_fall_done, clk, rst, $fell(busy) |-> done, "busy dropped without a result")
  `CHK_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !busy && !done, "not idle after reset")

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
